// ===== src/ope_pkg.sv =====
// Shared constants, command and status types and the score saturation helper
// for the optimal pick-ends game block. No dependencies.
package ope_pkg;

    localparam int MAX_CARDS = 64;
    localparam int CARD_W    = 16;
    localparam int SCORE_W   = 22;
    localparam int IDX_W     = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
    localparam int CNT_W     = $clog2(MAX_CARDS + 1);
    localparam int K_W       = $clog2(MAX_CARDS + 2);
    localparam int SUM_W     = CARD_W + $clog2(MAX_CARDS);
    localparam int ACC_W     = (SUM_W > SCORE_W) ? SUM_W : SCORE_W;
    localparam int DIAG_AW   = IDX_W + 1;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef struct packed {
        logic             store;
        logic [IDX_W-1:0] store_addr;
        logic             issue;
        logic [K_W-1:0]   k;
        logic [IDX_W-1:0] diag;
        logic             zero_win;
        logic             last_diag;
        logic             push;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_sts;

    function automatic logic [SCORE_W-1:0] sat_score(input logic [ACC_W-1:0] acc);
        logic [SCORE_W-1:0] res;
        if (acc > ACC_W'(SCORE_MAX)) begin
            res = SCORE_MAX;
        end else begin
            res = acc[SCORE_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== src/ope_stream_if.sv =====
// Valid/ready channel interfaces for card items and score items.
// Depends on ope_pkg for field widths.
interface ope_card_if;
    logic                       valid;
    logic                       ready;
    logic [ope_pkg::CARD_W-1:0] card_value;
    logic                       last_card;

    modport source (output valid, output card_value, output last_card, input ready);
    modport sink   (input valid, input card_value, input last_card, output ready);
endinterface

interface ope_score_if;
    logic                        valid;
    logic                        ready;
    logic [ope_pkg::SCORE_W-1:0] best_score;
    logic                        too_many;

    modport source (output valid, output best_score, output too_many, input ready);
    modport sink   (input valid, input best_score, input too_many, output ready);
endinterface

// ===== src/ope_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module ope_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== src/ope_ctrl.sv =====
// Controller: input handshake, card count, diagonal sequencing and result hand-off.
// Depends on ope_pkg.
module ope_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic          o_too_many,
    output ope_pkg::t_cmd o_cmd,
    input  ope_pkg::t_sts i_sts
);
    import ope_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_PUSH  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_n, n_n;
    logic [IDX_W-1:0] r_diag, n_diag;
    logic [K_W-1:0]   r_k, n_k;
    logic             r_ovf, n_ovf;
    logic             r_out_valid, n_out_valid;
    logic             r_too_many, n_too_many;

    logic             w_accept;
    logic             w_room;
    logic [CNT_W-1:0] w_len;
    logic [K_W-1:0]   w_end_k;
    t_cmd             w_cmd;

    assign w_accept = i_in_valid && (r_state == ST_LOAD);
    assign w_room   = (r_count < CNT_W'(MAX_CARDS));
    assign w_len    = r_n - CNT_W'(r_diag);
    assign w_end_k  = K_W'(w_len) + K_W'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_n         = r_n;
        n_diag      = r_diag;
        n_k         = r_k;
        n_ovf       = r_ovf;
        n_too_many  = r_too_many;
        n_out_valid = r_out_valid && !i_out_ready;

        w_cmd            = '0;
        w_cmd.store_addr = r_count[IDX_W-1:0];
        w_cmd.k          = r_k;
        w_cmd.diag       = r_diag;
        w_cmd.zero_win   = (CNT_W'(r_diag) < CNT_W'(2));
        w_cmd.last_diag  = ((CNT_W'(r_diag) + CNT_W'(1)) == r_n);

        case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_room) begin
                        w_cmd.store = 1'b1;
                        n_count     = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_last) begin
                        n_n     = w_room ? (r_count + CNT_W'(1)) : r_count;
                        n_diag  = '0;
                        n_k     = '0;
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                w_cmd.issue = 1'b1;
                if (r_k == w_end_k) begin
                    n_k = '0;
                    if (w_cmd.last_diag) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_diag = r_diag + IDX_W'(1);
                    end
                end else begin
                    n_k = r_k + K_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.push  = 1'b1;
                    n_out_valid = 1'b1;
                    n_too_many  = r_ovf;
                    n_ovf       = 1'b0;
                    n_count     = '0;
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_n         <= '0;
            r_diag      <= '0;
            r_k         <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_too_many  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_n         <= n_n;
            r_diag      <= n_diag;
            r_k         <= n_k;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_too_many  <= n_too_many;
        end
    end

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_too_many  = r_too_many;
    assign o_cmd       = w_cmd;

endmodule

// ===== src/ope_dp.sv =====
// Datapath: card store, two-bank diagonal store and the cell pipeline.
// Depends on ope_pkg and ope_ram.
module ope_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ope_pkg::CARD_W-1:0] i_card_value,
    input  ope_pkg::t_cmd              i_cmd,
    output ope_pkg::t_sts              o_sts,
    output logic [ope_pkg::SCORE_W-1:0] o_best_score
);
    import ope_pkg::*;

    typedef struct packed {
        logic             valid;
        logic             calc;
        logic             zero_win;
        logic             last_diag;
        logic             bank;
        logic [IDX_W-1:0] idx;
    } t_stage;

    t_stage             r_s1, r_s2, r_s3;
    logic [ACC_W-1:0]   r_w0, r_w1, r_w2;
    logic [CARD_W-1:0]  r_ci, r_cj;
    logic [ACC_W-1:0]   r_vf, r_vb;
    logic [SCORE_W-1:0] r_final;
    logic [SCORE_W-1:0] r_out_score;

    logic [K_W-1:0]     w_i_full;
    logic [IDX_W-1:0]   w_card_a;
    logic [IDX_W-1:0]   w_card_b;
    logic [CARD_W-1:0]  w_card_rd_a;
    logic [CARD_W-1:0]  w_card_rd_b;
    logic [ACC_W-1:0]   w_diag_rd;
    logic [ACC_W-1:0]   w_win_in;
    logic [ACC_W-1:0]   w_min_f;
    logic [ACC_W-1:0]   w_min_b;
    logic [ACC_W-1:0]   w_best;

    assign w_i_full = i_cmd.k - K_W'(2);
    assign w_card_a = w_i_full[IDX_W-1:0];
    assign w_card_b = w_card_a + i_cmd.diag;

    ope_ram #(
        .WIDTH  (CARD_W),
        .DEPTH  (MAX_CARDS),
        .ADDR_W (IDX_W)
    ) u_card_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.store),
        .i_waddr   (i_cmd.store_addr),
        .i_wdata   (i_card_value),
        .i_raddr_a (w_card_a),
        .i_raddr_b (w_card_b),
        .o_rdata_a (w_card_rd_a),
        .o_rdata_b (w_card_rd_b)
    );

    ope_ram #(
        .WIDTH  (ACC_W),
        .DEPTH  (2 * MAX_CARDS),
        .ADDR_W (DIAG_AW)
    ) u_diag_ram (
        .i_clk     (i_clk),
        .i_we      (r_s3.valid),
        .i_waddr   ({r_s3.bank, r_s3.idx}),
        .i_wdata   (w_best),
        .i_raddr_a ({i_cmd.diag[0], i_cmd.k[IDX_W-1:0]}),
        .i_raddr_b ('0),
        .o_rdata_a (w_diag_rd),
        .o_rdata_b ()
    );

    assign w_win_in = r_s1.zero_win ? '0 : w_diag_rd;
    assign w_min_f  = (r_w2 <= r_w1) ? r_w2 : r_w1;
    assign w_min_b  = (r_w1 <= r_w0) ? r_w1 : r_w0;
    assign w_best   = (r_vf >= r_vb) ? r_vf : r_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s1.valid     <= i_cmd.issue;
            r_s1.calc      <= (i_cmd.k >= K_W'(2));
            r_s1.zero_win  <= i_cmd.zero_win;
            r_s1.last_diag <= i_cmd.last_diag;
            r_s1.bank      <= i_cmd.diag[0];
            r_s1.idx       <= w_card_a;
            r_s2.valid     <= r_s1.valid && r_s1.calc;
            r_s2.calc      <= r_s1.calc;
            r_s2.zero_win  <= r_s1.zero_win;
            r_s2.last_diag <= r_s1.last_diag;
            r_s2.bank      <= r_s1.bank;
            r_s2.idx       <= r_s1.idx;
            r_s3           <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            r_w0 <= r_w1;
            r_w1 <= r_w2;
            r_w2 <= w_win_in;
            r_ci <= w_card_rd_a;
            r_cj <= w_card_rd_b;
        end
        r_vf <= ACC_W'(r_ci) + w_min_f;
        r_vb <= ACC_W'(r_cj) + w_min_b;
        if (r_s3.valid && r_s3.last_diag) begin
            r_final <= sat_score(w_best);
        end
        if (i_cmd.push) begin
            r_out_score <= r_final;
        end
    end

    assign o_sts.busy   = r_s1.valid || r_s2.valid || r_s3.valid;
    assign o_best_score = r_out_score;

endmodule

// ===== src/optimal_pick_ends_game_dp.sv =====
// Top level of the optimal pick-ends game scorer.
// Depends on ope_pkg, ope_stream_if, ope_ctrl and ope_dp.
//
// Usage: cards arrive on i_card, one per item, in row order. The item with
// last_card set closes the row; one item then leaves on o_score carrying the
// best total the first player can secure and too_many, which is set when the
// row held more than MAX_CARDS cards (the extra cards are dropped).
// Input items are taken one per cycle while a row is loading. After the last
// card of an N-card row, i_card.ready stays low while the interval table is
// filled one diagonal at a time, one cell per cycle; each diagonal starts with
// two priming reads that fill the three-entry window from the previous
// diagonal of the same parity. The cell pipeline then drains and the score
// is handed to the output register. The output register decouples the two
// sides: loading of the next row starts while the previous score still
// waits. If the receiver stalls, a finished score waits in the datapath
// while the controller holds until the output register is free.
// Reset is synchronous and active low; it empties the row and the output
// register. The stores need no clearing, since each cell is written before
// it is read.
module optimal_pick_ends_game_dp (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ope_card_if.sink    i_card,
    ope_score_if.source o_score
);
    import ope_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_out_valid;
    logic w_too_many;
    logic [SCORE_W-1:0] w_best_score;

    ope_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_card.valid),
        .i_in_last   (i_card.last_card),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_score.ready),
        .o_out_valid (w_out_valid),
        .o_too_many  (w_too_many),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    ope_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_card_value (i_card.card_value),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_best_score (w_best_score)
    );

    assign i_card.ready       = w_in_ready;
    assign o_score.valid      = w_out_valid;
    assign o_score.too_many   = w_too_many;
    assign o_score.best_score = w_best_score;

endmodule

// ===== src/ope_checker.sv =====
// Port-level checks for the optimal pick-ends game scorer, bound to the top level.
// Depends on ope_pkg and optimal_pick_ends_game_dp.
module ope_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_last,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [ope_pkg::SCORE_W-1:0] i_best_score,
    input logic                        i_too_many
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("Result item present right after reset.");

    a_last_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("Input still ready after the last card of a row.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result item dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_best_score) && $stable(i_too_many))
        else $error("Result payload changed while stalled.");

endmodule

bind optimal_pick_ends_game_dp ope_checker u_ope_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_card.valid),
    .i_in_ready   (i_card.ready),
    .i_in_last    (i_card.last_card),
    .i_out_valid  (o_score.valid),
    .i_out_ready  (o_score.ready),
    .i_best_score (o_score.best_score),
    .i_too_many   (o_score.too_many)
);
